// File: hw/rtl/olbavg_pkg.sv
// ----------------------------------------------------------------------------
// olbavg_pkg
// Shared widths, codes and helpers for the outlier-rejecting batch average.
// ----------------------------------------------------------------------------
package olbavg_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    localparam int SAMPLE_W = 32;
    localparam int TEMP_W   = 16;
    localparam int COUNT_W  = 16;
    localparam int SUM_W    = 48;
    localparam int TSUM_W   = 32;
    localparam int BAND_W   = 31;
    localparam int MODE_W   = 2;
    localparam int WIDE_W   = SAMPLE_W + 2;

    localparam logic [BAND_W-1:0]  BAND_RESET = BAND_W'(39146);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // input stream layout
    localparam int IN_DATA_W = SAMPLE_W + 2 * TEMP_W;
    localparam int IN_USER_W = MODE_W + 1;

    // shared divider: unsigned, one quotient bit per cycle
    localparam int DIV_NW = SUM_W;
    localparam int DIV_DW = COUNT_W;
    localparam int DIV_CW = $clog2(DIV_NW);

    typedef logic [MODE_W-1:0] mode_t;

    localparam mode_t MODE_IDLE = 2'd0;
    localparam mode_t MODE_ACC  = 2'd1;
    localparam mode_t MODE_FIN  = 2'd2;

    function automatic int kept_w(int depth);
        return $clog2(depth + 1);
    endfunction

    function automatic int out_w(int depth);
        return ((2 * SAMPLE_W + kept_w(depth) + COUNT_W + 2 * TEMP_W + 7) / 8) * 8;
    endfunction

endpackage

// File: hw/rtl/olbavg_div.sv
// ----------------------------------------------------------------------------
// olbavg_div
// Restoring unsigned divider, one quotient bit per cycle, shared by all
// divisions of a batch result.
// ----------------------------------------------------------------------------
module olbavg_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [olbavg_pkg::DIV_NW-1:0] dividend,
    input  logic [olbavg_pkg::DIV_DW-1:0] divisor,
    output logic                        done,
    output logic [olbavg_pkg::DIV_NW-1:0] quotient
);
    import olbavg_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] step_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;

    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_CW'(DIV_NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
            // remainder stays below the divisor, so the top trial bit drops
            rem_reg <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: hw/rtl/outlier_rejecting_batch_average.sv
// ----------------------------------------------------------------------------
// outlier_rejecting_batch_average
// Batch mean of Q8.24 samples, trimmed to a band around the plain mean,
// with truncated temperature averages.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata (low bit up)                      | tuser
//  s_axis   | in        | sample_value, temp_first, temp_second   | mode, batch_kind
//  m_axis   | out       | plain_mean, trimmed_mean, kept_count,   | result_kind
//           |           | sample_count, temp_first_avg,           |
//           |           | temp_second_avg, zero fill              |
//  cfg      | in        | band_half_width on cfg_we               | -
//
//  accumulate and clear transactions leave the input ready.
//  a finish transaction makes three passes of the shared divider, four when
//  more than one sample is kept, plus a scan of min(n, STORE_DEPTH) stored
//  samples with one store read per cycle.
//  a result waits in the output register; a second finish is taken but holds
//  the input stalled in its last state until that register is free.
//  rst_n clears the sums and counters; the sample store is not cleared.
// ----------------------------------------------------------------------------
module outlier_rejecting_batch_average #(
    parameter int STORE_DEPTH = olbavg_pkg::STORE_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    // sample_value, temp_first, temp_second
    input  logic [olbavg_pkg::IN_DATA_W-1:0]        s_tdata,
    // mode, batch_kind
    input  logic [olbavg_pkg::IN_USER_W-1:0]        s_tuser,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // plain_mean, trimmed_mean, kept_count, sample_count,
    // temp_first_avg, temp_second_avg, zero fill
    output logic [olbavg_pkg::out_w(STORE_DEPTH)-1:0] m_tdata,
    // result_kind
    output logic                                    m_tuser,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_we,
    input  logic [olbavg_pkg::BAND_W-1:0]           cfg_wdata
);
    import olbavg_pkg::*;

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int CW     = kept_w(STORE_DEPTH);
    localparam int KSUM_W = SAMPLE_W + CW;
    localparam int OUT_W  = out_w(STORE_DEPTH);
    localparam int PAD_W  = OUT_W - (2 * SAMPLE_W + CW + COUNT_W + 2 * TEMP_W);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MEAN_GO   = 4'd1;
    localparam logic [3:0] S_MEAN_WAIT = 4'd2;
    localparam logic [3:0] S_BAND      = 4'd3;
    localparam logic [3:0] S_SCAN      = 4'd4;
    localparam logic [3:0] S_TRIM_GO   = 4'd5;
    localparam logic [3:0] S_TRIM_WAIT = 4'd6;
    localparam logic [3:0] S_T1_GO     = 4'd7;
    localparam logic [3:0] S_T1_WAIT   = 4'd8;
    localparam logic [3:0] S_T2_GO     = 4'd9;
    localparam logic [3:0] S_T2_WAIT   = 4'd10;
    localparam logic [3:0] S_DONE      = 4'd11;

    // input fields
    mode_t                in_mode;
    logic [SAMPLE_W-1:0]  in_sample;
    logic [TEMP_W-1:0]    in_t1;
    logic [TEMP_W-1:0]    in_t2;

    assign in_mode   = s_tuser[MODE_W-1:0];
    assign in_sample = s_tdata[SAMPLE_W-1:0];
    assign in_t1     = s_tdata[SAMPLE_W +: TEMP_W];
    assign in_t2     = s_tdata[SAMPLE_W + TEMP_W +: TEMP_W];

    logic [3:0]               state_reg;
    logic [3:0]               state_next;
    logic [BAND_W-1:0]        band_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [TSUM_W-1:0]        t1sum_reg;
    logic [TSUM_W-1:0]        t2sum_reg;
    logic [COUNT_W-1:0]       count_reg;
    logic [AW-1:0]            wr_ptr_reg;
    logic                     kind_reg;
    logic                     neg_reg;
    logic signed [SAMPLE_W-1:0] mean_reg;
    logic signed [SAMPLE_W-1:0] trim_reg;
    logic [TEMP_W-1:0]        t1avg_reg;
    logic [TEMP_W-1:0]        t2avg_reg;
    logic signed [WIDE_W-1:0] lo_reg;
    logic signed [WIDE_W-1:0] hi_reg;
    logic [CW-1:0]            scan_idx_reg;
    logic                     rd_vld_reg;
    logic [SAMPLE_W-1:0]      rd_data_reg;
    logic signed [KSUM_W-1:0] ksum_reg;
    logic [CW-1:0]            kept_reg;
    logic                     out_vld_reg;
    logic [OUT_W-1:0]         out_data_reg;
    logic                     out_kind_reg;

    logic [SAMPLE_W-1:0]      store_mem [STORE_DEPTH];

    logic accept;
    logic absorb;
    logic clear_in;
    logic out_free;
    logic issue;
    logic rd_en;
    logic in_band;
    logic [CW-1:0] scan_n;
    logic signed [WIDE_W-1:0] rd_wide;

    // shared divider
    logic                div_start;
    logic [DIV_NW-1:0]   div_num;
    logic [DIV_DW-1:0]   div_den;
    logic                div_neg;
    logic                div_done;
    logic [DIV_NW-1:0]   div_quo;
    logic [DIV_NW-1:0]   div_signed;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign absorb   = accept && (in_mode inside {MODE_ACC, MODE_FIN})
                      && (count_reg != COUNT_MAX);
    assign clear_in = accept && !(in_mode inside {MODE_ACC, MODE_FIN});
    assign out_free = !out_vld_reg || m_tready;

    assign scan_n  = (count_reg < COUNT_W'(STORE_DEPTH)) ? count_reg[CW-1:0]
                                                        : CW'(STORE_DEPTH);
    assign issue   = scan_idx_reg < scan_n;
    assign rd_en   = (state_reg == S_SCAN) && issue;
    assign rd_wide = WIDE_W'($signed(rd_data_reg));
    assign in_band = (rd_wide > lo_reg) && (rd_wide < hi_reg);

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = count_reg;
        div_neg   = 1'b0;
        case (state_reg)
            S_MEAN_GO:
            begin
                div_start = 1'b1;
                div_neg   = sum_reg < 0;
                div_num   = div_neg ? DIV_NW'(-sum_reg) : DIV_NW'(sum_reg);
            end
            S_TRIM_GO:
            begin
                div_start = 1'b1;
                div_neg   = ksum_reg < 0;
                div_num   = div_neg ? DIV_NW'(-ksum_reg) : DIV_NW'(ksum_reg);
                div_den   = DIV_DW'(kept_reg);
            end
            S_T1_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(t1sum_reg);
            end
            S_T2_GO:
            begin
                div_start = 1'b1;
                div_num   = DIV_NW'(t2sum_reg);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    assign div_signed = neg_reg ? (~div_quo + 1'b1) : div_quo;

    olbavg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && in_mode == MODE_FIN)
                    state_next = S_MEAN_GO;
            S_MEAN_GO:   state_next = S_MEAN_WAIT;
            S_MEAN_WAIT: if (div_done) state_next = S_BAND;
            S_BAND:      state_next = S_SCAN;
            S_SCAN:
                if (!issue && !rd_vld_reg)
                    state_next = (kept_reg > CW'(1)) ? S_TRIM_GO : S_T1_GO;
            S_TRIM_GO:   state_next = S_TRIM_WAIT;
            S_TRIM_WAIT: if (div_done) state_next = S_T1_GO;
            S_T1_GO:     state_next = S_T1_WAIT;
            S_T1_WAIT:   if (div_done) state_next = S_T2_GO;
            S_T2_GO:     state_next = S_T2_WAIT;
            S_T2_WAIT:   if (div_done) state_next = S_DONE;
            S_DONE:      if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // control and batch state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            band_reg     <= BAND_RESET;
            sum_reg      <= '0;
            t1sum_reg    <= '0;
            t2sum_reg    <= '0;
            count_reg    <= '0;
            wr_ptr_reg   <= '0;
            scan_idx_reg <= '0;
            rd_vld_reg   <= 1'b0;
            kept_reg     <= '0;
            ksum_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                band_reg <= cfg_wdata;

            if (absorb)
            begin
                sum_reg    <= sum_reg + SUM_W'($signed(in_sample));
                t1sum_reg  <= t1sum_reg + TSUM_W'(in_t1);
                t2sum_reg  <= t2sum_reg + TSUM_W'(in_t2);
                count_reg  <= count_reg + 1'b1;
                wr_ptr_reg <= (wr_ptr_reg == AW'(STORE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
            end
            else if (clear_in || (state_reg == S_DONE && out_free))
            begin
                sum_reg    <= '0;
                t1sum_reg  <= '0;
                t2sum_reg  <= '0;
                count_reg  <= '0;
                wr_ptr_reg <= '0;
            end

            if (state_reg == S_BAND)
            begin
                scan_idx_reg <= '0;
                kept_reg     <= '0;
                ksum_reg     <= '0;
            end
            else if (state_reg == S_SCAN)
            begin
                if (issue)
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                if (rd_vld_reg && in_band)
                begin
                    ksum_reg <= ksum_reg + KSUM_W'($signed(rd_data_reg));
                    kept_reg <= kept_reg + 1'b1;
                end
            end
            rd_vld_reg <= rd_en;

            if (state_reg == S_DONE && out_free)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    // datapath results
    always_ff @(posedge clk)
    begin
        if (accept && in_mode == MODE_FIN)
            kind_reg <= s_tuser[MODE_W];
        if (div_start)
            neg_reg <= div_neg;
        if (state_reg == S_MEAN_WAIT && div_done)
            mean_reg <= $signed(div_signed[SAMPLE_W-1:0]);
        if (state_reg == S_BAND)
        begin
            lo_reg <= WIDE_W'(mean_reg) - $signed(WIDE_W'(band_reg));
            hi_reg <= WIDE_W'(mean_reg) + $signed(WIDE_W'(band_reg));
        end
        if (state_reg == S_SCAN && !issue && !rd_vld_reg)
            trim_reg <= mean_reg;
        if (state_reg == S_TRIM_WAIT && div_done)
            trim_reg <= $signed(div_signed[SAMPLE_W-1:0]);
        if (state_reg == S_T1_WAIT && div_done)
            t1avg_reg <= div_quo[TEMP_W-1:0];
        if (state_reg == S_T2_WAIT && div_done)
            t2avg_reg <= div_quo[TEMP_W-1:0];
        if (state_reg == S_DONE && out_free)
        begin
            out_data_reg <= {{PAD_W{1'b0}}, t2avg_reg, t1avg_reg, count_reg,
                             kept_reg, trim_reg, mean_reg};
            out_kind_reg <= kind_reg;
        end
    end

    // sample store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (absorb)
            store_mem[wr_ptr_reg] <= in_sample;
        if (rd_en)
            rd_data_reg <= store_mem[scan_idx_reg[AW-1:0]];
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

// File: hw/rtl/olbavg_chk.sv
// ----------------------------------------------------------------------------
// olbavg_chk
// Port-level checks for the outlier-rejecting batch average, bound to the
// top level.
// ----------------------------------------------------------------------------
module olbavg_chk #(
    parameter int STORE_DEPTH = olbavg_pkg::STORE_DEPTH_DEF
) (
    input logic                                    clk,
    input logic                                    rst_n,
    input logic [olbavg_pkg::IN_USER_W-1:0]        s_tuser,
    input logic                                    s_tvalid,
    input logic                                    s_tready,
    input logic [olbavg_pkg::out_w(STORE_DEPTH)-1:0] m_tdata,
    input logic                                    m_tuser,
    input logic                                    m_tvalid,
    input logic                                    m_tready
);
    import olbavg_pkg::*;

    localparam int CW = kept_w(STORE_DEPTH);

    logic               s_acc;
    logic [CW-1:0]      kept;
    logic [COUNT_W-1:0] count;

    assign s_acc = s_tvalid && s_tready;
    assign kept  = m_tdata[2 * SAMPLE_W +: CW];
    assign count = m_tdata[2 * SAMPLE_W + CW +: COUNT_W];

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a finish transaction starts the multi-cycle computation
    a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tuser[MODE_W-1:0] == MODE_FIN |=> !s_tready)
        else $error("input taken during batch computation");

    // accumulate transactions never stall the input
    a_acc_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && s_tuser[MODE_W-1:0] == MODE_ACC |=> s_tready)
        else $error("accumulate blocked the input");

    // a new result appears just as the block goes back to waiting for input
    a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result raised while busy");

    // kept samples never outnumber stored or counted samples
    a_kept_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> COUNT_W'(kept) <= count && kept <= CW'(STORE_DEPTH)
                     && count != '0)
        else $error("kept count out of range");

endmodule

bind outlier_rejecting_batch_average olbavg_chk #(.STORE_DEPTH(STORE_DEPTH)) u_olbavg_chk (.*);

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the outlier-rejecting batch average: streams
// accumulate, finish and clear transactions with random gaps and random
// output stalls. A cycle-free model of the batch sums and sample store
// predicts every averaged result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb_top;

    import olbavg_pkg::*;

    localparam int CLK_PERIOD       = 12;
    localparam int SETTLE_CYCLES    = 300;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int TIMEOUT_CYCLES   = 3_000_000;
    localparam int COUNT_LIMIT      = 65535;
    localparam int KEPT_W           = kept_w(STORE_DEPTH_DEF);
    localparam int OUT_W            = out_w(STORE_DEPTH_DEF);
    localparam int RES_W            = 2 * SAMPLE_W + KEPT_W + COUNT_W + 2 * TEMP_W;
    localparam longint SAMPLE_HI    = 64'sd2147483647;
    localparam longint SAMPLE_LO    = -64'sd2147483648;
    localparam logic [BAND_W-1:0] BAND_MAX = '1;

    // mode code that the block treats as a clear
    localparam mode_t MODE_SPARE = 2'd3;

    typedef struct {
        mode_t                      mode;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TEMP_W-1:0]          temp1;
        logic [TEMP_W-1:0]          temp2;
        logic                       kind;
        int                         gap;
    } sample_item_t;

    typedef struct packed {
        logic [OUT_W-RES_W-1:0]     fill;
        logic [TEMP_W-1:0]          temp_second_avg;
        logic [TEMP_W-1:0]          temp_first_avg;
        logic [COUNT_W-1:0]         sample_count;
        logic [KEPT_W-1:0]          kept_count;
        logic signed [SAMPLE_W-1:0] trimmed_mean;
        logic signed [SAMPLE_W-1:0] plain_mean;
    } avg_word_t;

    typedef struct {
        avg_word_t word;
        logic      kind;
    } avg_expect_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic [IN_DATA_W-1:0] s_tdata = '0;     // sample_value, temp_first, temp_second
    logic [IN_USER_W-1:0] s_tuser = '0;     // mode, batch_kind
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [OUT_W-1:0]     m_tdata;          // plain_mean, trimmed_mean, kept_count,
                                            // sample_count, temp_first_avg,
                                            // temp_second_avg, zero fill
    logic                 m_tuser;          // result_kind
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [BAND_W-1:0]    cfg_wdata = '0;

    sample_item_t pending_items[$];
    avg_expect_t  expected_averages[$];
    int           error_count = 0;

    // batch model
    logic signed [SAMPLE_W-1:0] batch_store[STORE_DEPTH_DEF];
    longint                     batch_sum = 0;
    longint                     batch_temp1_sum = 0;
    longint                     batch_temp2_sum = 0;
    int                         batch_count = 0;
    logic [BAND_W-1:0]          band_now = BAND_RESET;

    // sender and receiver pacing
    int gap_left = 0;
    bit gap_done = 1'b0;
    int stall_left = 0;
    int window_left = 0;
    bit stalls_on = 1'b1;
    bit long_hold_req = 1'b0;

    outlier_rejecting_batch_average #(
        .STORE_DEPTH(STORE_DEPTH_DEF)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int pick_gap_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_gap(input bit calm);
        if (calm || $urandom_range(0, 99) < 55)
            return 0;
        return pick_gap_len();
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input longint center,
                                                              input longint spread);
        longint          v;
        longint unsigned r;
        case ($urandom_range(0, 19))
            0: return $urandom;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            default:
            begin
                r = {$urandom, $urandom};
                v = center + longint'(r % longint'(2 * spread + 1)) - spread;
                if (v > SAMPLE_HI)
                    v = SAMPLE_HI;
                if (v < SAMPLE_LO)
                    v = SAMPLE_LO;
                return 32'(v);
            end
        endcase
    endfunction

    task automatic queue_item(input mode_t mode, input logic signed [SAMPLE_W-1:0] sample,
                              input logic [TEMP_W-1:0] temp1, input logic [TEMP_W-1:0] temp2,
                              input logic kind, input int gap);
        sample_item_t it;
        it.mode   = mode;
        it.sample = sample;
        it.temp1  = temp1;
        it.temp2  = temp2;
        it.kind   = kind;
        it.gap    = gap;
        pending_items.push_back(it);
    endtask

    task automatic queue_clear(input bit calm);
        queue_item($urandom_range(0, 1) ? MODE_IDLE : MODE_SPARE, $urandom, 16'($urandom),
                   16'($urandom), 1'($urandom), pick_gap(calm));
    endtask

    // well-formed batches with random content, a few clears mixed in
    task automatic run_random_phase(input int budget);
        int     used;
        int     len;
        int     noise_at;
        int     r;
        bit     calm;
        longint center;
        longint spread;
        longint band_l;
        used = 0;
        band_l = band_now;
        while (used < budget)
        begin
            calm = ($urandom_range(0, 9) < 3);
            r = $urandom_range(0, 99);
            if (r < 65)
                len = $urandom_range(1, 6);
            else if (r < 88)
                len = $urandom_range(7, 24);
            else if (r < 97)
                len = $urandom_range(25, 90);
            else
                len = $urandom_range(91, 150);
            case ($urandom_range(0, 5))
                0, 1: center = longint'($signed($urandom));
                2: center = longint'($urandom_range(0, 2000)) - 1000;
                3: center = SAMPLE_HI - longint'($urandom_range(0, 100000));
                4: center = SAMPLE_LO + longint'($urandom_range(0, 100000));
                default: center = longint'($signed($urandom)) >>> 8;
            endcase
            case ($urandom_range(0, 4))
                0: spread = 0;
                1: spread = band_l / 2;
                2: spread = band_l;
                3: spread = band_l * 3;
                default: spread = longint'($urandom_range(0, 1 << 20));
            endcase
            if ($urandom_range(0, 99) < 8)
                queue_clear(calm);
            noise_at = ($urandom_range(0, 99) < 6) ? $urandom_range(0, len - 1) : -1;
            for (int i = 0; i < len; i++)
            begin
                if (i == noise_at)
                    queue_clear(calm);
                queue_item((i == len - 1) ? MODE_FIN : MODE_ACC, pick_sample(center, spread),
                           16'($urandom), 16'($urandom), 1'($urandom), pick_gap(calm));
            end
            used += len;
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_tvalid || expected_averages.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_band(input logic [BAND_W-1:0] value);
        wait_idle();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        band_now  = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [BAND_W-1:0] pick_band();
        if ($urandom_range(0, 1))
            return BAND_W'($urandom_range(1, 2_000_000));
        return BAND_W'($urandom);
    endfunction

    task automatic update_batch(input mode_t mode, input logic signed [SAMPLE_W-1:0] sample,
                                input logic [TEMP_W-1:0] temp1,
                                input logic [TEMP_W-1:0] temp2, input logic kind);
        longint      mean;
        longint      lo;
        longint      hi;
        longint      kept_sum;
        longint      v;
        longint      band_l;
        int          kept;
        int          scan;
        avg_expect_t e;
        if (!(mode inside {MODE_ACC, MODE_FIN}))
        begin
            batch_sum = 0;
            batch_temp1_sum = 0;
            batch_temp2_sum = 0;
            batch_count = 0;
            return;
        end
        // a saturated batch ignores further samples
        if (batch_count < COUNT_LIMIT)
        begin
            batch_store[batch_count % STORE_DEPTH_DEF] = sample;
            batch_sum += longint'(sample);
            batch_temp1_sum += temp1;
            batch_temp2_sum += temp2;
            batch_count++;
        end
        if (mode == MODE_ACC)
            return;
        band_l = band_now;
        mean = batch_sum / longint'(batch_count);
        lo = mean - band_l;
        hi = mean + band_l;
        scan = (batch_count < STORE_DEPTH_DEF) ? batch_count : STORE_DEPTH_DEF;
        kept = 0;
        kept_sum = 0;
        for (int i = 0; i < scan; i++)
        begin
            v = batch_store[i];
            if (v > lo && v < hi)
            begin
                kept_sum += v;
                kept++;
            end
        end
        e.word = '0;
        e.word.plain_mean      = 32'(mean);
        e.word.trimmed_mean    = (kept > 1) ? 32'(kept_sum / longint'(kept)) : 32'(mean);
        e.word.kept_count      = KEPT_W'(kept);
        e.word.sample_count    = COUNT_W'(batch_count);
        e.word.temp_first_avg  = TEMP_W'(batch_temp1_sum / batch_count);
        e.word.temp_second_avg = TEMP_W'(batch_temp2_sum / batch_count);
        e.kind = kind;
        expected_averages.push_back(e);
        batch_sum = 0;
        batch_temp1_sum = 0;
        batch_temp2_sum = 0;
        batch_count = 0;
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : sender
        sample_item_t nx;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
            gap_done <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (gap_left != 0)
            begin
                s_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() != 0)
            begin
                if (pending_items[0].gap != 0 && !gap_done)
                begin
                    s_tvalid <= 1'b0;
                    gap_left <= pending_items[0].gap - 1;
                    gap_done <= 1'b1;
                end
                else
                begin
                    nx = pending_items.pop_front();
                    s_tdata  <= {nx.temp2, nx.temp1, nx.sample};
                    s_tuser  <= {nx.kind, nx.mode};
                    s_tvalid <= 1'b1;
                    gap_done <= 1'b0;
                end
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: random stalls in windows, plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            stall_left  <= 0;
            window_left <= 0;
            stalls_on   <= 1'b1;
        end
        else
        begin
            if (window_left == 0)
            begin
                window_left <= 400;
                stalls_on   <= ($urandom_range(0, 9) > 2);
            end
            else
                window_left <= window_left - 1;
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left <= LONG_HOLD_CYCLES;
                m_tready   <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                m_tready   <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                stall_left <= pick_gap_len() - 1;
                m_tready   <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // monitor: predict on input transactions, check output transactions
    always @(posedge clk)
    begin : monitor
        avg_word_t   got;
        avg_expect_t want;
        if (rst_n && s_tvalid && s_tready)
            update_batch(s_tuser[MODE_W-1:0], s_tdata[SAMPLE_W-1:0],
                         s_tdata[SAMPLE_W +: TEMP_W], s_tdata[SAMPLE_W + TEMP_W +: TEMP_W],
                         s_tuser[MODE_W]);
        if (rst_n && m_tvalid && m_tready)
        begin
            got = avg_word_t'(m_tdata);
            if (expected_averages.size() == 0)
            begin
                $error("output transaction with no average pending");
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                compare_field("plain_mean", want.word.plain_mean, got.plain_mean);
                compare_field("trimmed_mean", want.word.trimmed_mean, got.trimmed_mean);
                compare_field("kept_count", want.word.kept_count, got.kept_count);
                compare_field("sample_count", want.word.sample_count, got.sample_count);
                compare_field("temp_first_avg", want.word.temp_first_avg,
                              got.temp_first_avg);
                compare_field("temp_second_avg", want.word.temp_second_avg,
                              got.temp_second_avg);
                compare_field("result_kind", want.kind, m_tuser);
            end
        end
    end

    initial
    begin : stimulus
        logic signed [SAMPLE_W-1:0] base;
        base = 32'sh01000000;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset band
        queue_item(MODE_FIN, 32'sh7FFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1, pick_gap(0));
        queue_item(MODE_ACC, 32'sh80000000, 16'h0000, 16'h0000, 1'b0, pick_gap(0));
        queue_item(MODE_ACC, 32'sh80000000, 16'h0000, 16'h0000, 1'b0, pick_gap(0));
        queue_item(MODE_FIN, 32'sh80000000, 16'h0000, 16'h0000, 1'b0, pick_gap(0));
        // both samples sit exactly on the band edges
        queue_item(MODE_ACC, 32'sd0, 16'd1, 16'd2, 1'b0, pick_gap(0));
        queue_item(MODE_FIN, 32'sd78292, 16'd3, 16'd5, 1'b1, pick_gap(0));
        queue_item(MODE_ACC, 32'sd0, 16'd7, 16'd0, 1'b0, pick_gap(0));
        queue_item(MODE_ACC, 32'sd39146, 16'd8, 16'd1, 1'b0, pick_gap(0));
        queue_item(MODE_FIN, 32'sd78292, 16'd9, 16'd1, 1'b0, pick_gap(0));
        // negative sum, quotients truncate toward zero
        queue_item(MODE_ACC, -32'sd7, 16'hFFFF, 16'h0001, 1'b1, pick_gap(0));
        queue_item(MODE_ACC, 32'sd2, 16'hFFFE, 16'h0000, 1'b0, pick_gap(0));
        queue_item(MODE_FIN, 32'sd0, 16'h0000, 16'h0001, 1'b1, pick_gap(0));
        // one outlier dropped, three samples kept
        queue_item(MODE_ACC, base, 16'd100, 16'd200, 1'b0, pick_gap(0));
        queue_item(MODE_ACC, base + 32'sd100, 16'd101, 16'd201, 1'b0, pick_gap(0));
        queue_item(MODE_ACC, base - 32'sd100, 16'd102, 16'd202, 1'b0, pick_gap(0));
        queue_item(MODE_FIN, base + 32'sd60000, 16'd103, 16'd203, 1'b0, pick_gap(0));
        // clears: idle and the unused mode code
        queue_item(MODE_IDLE, 32'sh5A5A5A5A, 16'hA5A5, 16'h5A5A, 1'b1, pick_gap(0));
        queue_item(MODE_ACC, 32'sd5, 16'd50, 16'd60, 1'b0, pick_gap(0));
        queue_item(MODE_SPARE, 32'sd5, 16'd50, 16'd60, 1'b1, pick_gap(0));
        queue_item(MODE_FIN, 32'sd9, 16'd4, 16'd6, 1'b0, pick_gap(0));
        queue_item(MODE_ACC, 32'sd1000, 16'd1000, 16'd1000, 1'b1, pick_gap(0));
        queue_item(MODE_IDLE, 32'sd0, 16'd0, 16'd0, 1'b0, pick_gap(0));
        queue_item(MODE_FIN, 32'sd11, 16'd12, 16'd13, 1'b1, pick_gap(0));

        write_band('0);
        run_random_phase(220);
        write_band(BAND_MAX);
        run_random_phase(220);

        write_band(BAND_RESET);
        long_hold_req = 1'b1;
        run_random_phase(260);
        write_band(BAND_W'(1));
        run_random_phase(200);
        for (int p = 0; p < 3; p++)
        begin
            write_band(pick_band());
            run_random_phase(220);
        end

        wait_idle();
        if (error_count == 0 && expected_averages.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
